[rtl/msfc_pkg.sv]
package msfc_pkg;

	localparam int TIME_W = 32;
	localparam int DRAW_W = 25;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W = 3;

	// power modes
	localparam logic [2:0] MODE_AWAKE     = 3'd0;
	localparam logic [2:0] MODE_FADE_OUT  = 3'd1;
	localparam logic [2:0] MODE_ASLEEP    = 3'd2;
	localparam logic [2:0] MODE_FADE_IN   = 3'd3;
	localparam logic [2:0] MODE_DREAM_IN  = 3'd4;
	localparam logic [2:0] MODE_DREAM_LIT = 3'd5;
	localparam logic [2:0] MODE_DREAM_OUT = 3'd6;

	// item kinds
	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_WAKE   = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_TIMEOUT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_JITTER         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FADE           = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DREAM_INTERVAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DREAM_LIT      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THR     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE         = 3'd6;

	// reset values
	localparam logic [23:0] RST_SLEEP_TIMEOUT  = 24'd240000;
	localparam logic [15:0] RST_JITTER         = 16'd5000;
	localparam logic [15:0] RST_FADE           = 16'd1000;
	localparam logic [23:0] RST_DREAM_INTERVAL = 24'd30000;
	localparam logic [15:0] RST_DREAM_LIT      = 16'd2000;
	localparam logic [15:0] RST_MOTION_THR     = 16'd205;
	localparam logic [15:0] RST_SETTLE         = 16'd500;
	localparam logic [DRAW_W-1:0] RST_DREAM_WAIT = 25'd30000;
	localparam logic [DRAW_W-1:0] RST_TIMEOUT    = 25'd240000;

	localparam logic [7:0] SCALE_FULL = 8'd255;

	// squaring sequence operand select
	localparam logic [1:0] SQ_X   = 2'd0;
	localparam logic [1:0] SQ_Y   = 2'd1;
	localparam logic [1:0] SQ_Z   = 2'd2;
	localparam logic [1:0] SQ_THR = 2'd3;

	// divider step counts: remainder walks the whole random word,
	// fade quotient needs 8 bits
	localparam int DIV_MOD_STEPS   = TIME_W;
	localparam int DIV_SCALE_STEPS = 8;
	localparam int STEP_CNT_W      = $clog2(DIV_MOD_STEPS);

	typedef struct packed {
		logic       load_in;
		logic       mod_init;
		logic       div_step;
		logic       draw_calc;
		logic       tick1;
		logic       tick2;
		logic       tick3;
		logic       sq_step;
		logic [1:0] sq_idx;
		logic       decide;
		logic       base_only;
		logic       wake;
		logic       sc1;
		logic       sc2;
		logic       out_load;
	} msfc_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       sample_use;
		logic       baseline_valid;
		logic       scale_direct;
	} msfc_stat_t;

endpackage

[rtl/msfc_ctrl.sv]
module msfc_ctrl import msfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  msfc_stat_t stat,
	output msfc_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_MOD  = 4'd2;
	localparam logic [3:0] S_DRAW = 4'd3;
	localparam logic [3:0] S_T1   = 4'd4;
	localparam logic [3:0] S_T2   = 4'd5;
	localparam logic [3:0] S_T3   = 4'd6;
	localparam logic [3:0] S_SQ   = 4'd7;
	localparam logic [3:0] S_DEC  = 4'd8;
	localparam logic [3:0] S_BASE = 4'd9;
	localparam logic [3:0] S_WAKE = 4'd10;
	localparam logic [3:0] S_SC1  = 4'd11;
	localparam logic [3:0] S_SC2  = 4'd12;
	localparam logic [3:0] S_SDIV = 4'd13;
	localparam logic [3:0] S_FIN  = 4'd14;

	localparam logic [STEP_CNT_W-1:0] MOD_LAST   = STEP_CNT_W'(DIV_MOD_STEPS - 1);
	localparam logic [STEP_CNT_W-1:0] SCALE_LAST = STEP_CNT_W'(DIV_SCALE_STEPS - 1);

	logic [3:0]            state_q, state_d;
	logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
	logic                  out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				cnt_d = '0;
				case (stat.kind)
					KIND_TICK: begin
						cmd.mod_init = 1'b1;
						state_d      = S_MOD;
					end
					KIND_SAMPLE: begin
						if (!stat.sample_use)
							state_d = S_SC1;
						else if (stat.baseline_valid)
							state_d = S_SQ;
						else
							state_d = S_BASE;
					end
					KIND_WAKE: state_d = S_WAKE;
					default:   state_d = S_SC1;
				endcase
			end
			S_MOD: begin
				cmd.div_step = 1'b1;
				if (cnt_q == MOD_LAST) begin
					cnt_d   = '0;
					state_d = S_DRAW;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DRAW: begin
				cmd.draw_calc = 1'b1;
				state_d       = S_T1;
			end
			S_T1: begin
				cmd.tick1 = 1'b1;
				state_d   = S_T2;
			end
			S_T2: begin
				cmd.tick2 = 1'b1;
				state_d   = S_T3;
			end
			S_T3: begin
				cmd.tick3 = 1'b1;
				state_d   = S_SC1;
			end
			S_SQ: begin
				cmd.sq_step = 1'b1;
				cmd.sq_idx  = cnt_q[1:0];
				if (cnt_q[1:0] == SQ_THR) begin
					cnt_d   = '0;
					state_d = S_DEC;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DEC: begin
				cmd.decide = 1'b1;
				state_d    = S_SC1;
			end
			S_BASE: begin
				cmd.base_only = 1'b1;
				state_d       = S_SC1;
			end
			S_WAKE: begin
				cmd.wake = 1'b1;
				state_d  = S_SC1;
			end
			S_SC1: begin
				cmd.sc1 = 1'b1;
				state_d = S_SC2;
			end
			S_SC2: begin
				cmd.sc2 = 1'b1;
				cnt_d   = '0;
				state_d = stat.scale_direct ? S_FIN : S_SDIV;
			end
			S_SDIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == SCALE_LAST) begin
					cnt_d   = '0;
					state_d = S_FIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/msfc_dp.sv]
module msfc_dp import msfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  msfc_cmd_t             cmd,
	output msfc_stat_t            stat,
	input  logic [1:0]            kind,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic signed [15:0]    accel_x,
	input  logic signed [15:0]    accel_y,
	input  logic signed [15:0]    accel_z,
	input  logic                  sample_ok,
	input  logic [TIME_W-1:0]     random_word,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [2:0]            mode,
	output logic [7:0]            brightness_scale,
	output logic                  radio_on,
	output logic                  motion_seen,
	output logic                  forward_sample
);

	// registers
	logic [23:0] sleep_timeout_q, dream_int_q;
	logic [15:0] jitter_q, fade_q, dream_lit_q, thr_q, settle_q;

	// latched item
	logic [1:0]        kind_q;
	logic [TIME_W-1:0] now_q, rnd_q;
	logic signed [15:0] ax_q, ay_q, az_q;
	logic              ok_q;

	// controller state
	logic [2:0]        mode_q;
	logic [TIME_W-1:0] fade_start_q, last_motion_q, sleep_start_q, resume_q;
	logic [DRAW_W-1:0] dream_wait_q, timeout_q;
	logic              bv_q, seen_q, fwd_q;
	logic signed [15:0] px_q, py_q, pz_q;

	// working registers
	logic [16:0]       div_r_q;
	logic [TIME_W-1:0] div_sh_q;
	logic [7:0]        div_quo_q;
	logic              div_scale_q;
	logic [DRAW_W-1:0] draw_dream_q, draw_to_q;
	logic [15:0]       rem_q, num_x_q;
	logic [31:0]       product_q;
	logic [33:0]       sum_q;
	logic              fade_ge_q;

	logic [2:0] out_mode_q;
	logic [7:0] out_scale_q;
	logic       out_radio_q, out_seen_q, out_fwd_q;

	function automatic logic [DRAW_W-1:0] draw_val(input logic [23:0] base,
		input logic [16:0] md, input logic [15:0] jit);
		logic [DRAW_W-1:0] v;
		v = {1'b0, base} + {8'b0, md};
		return (v < {9'b0, jit}) ? '0 : v - {9'b0, jit};
	endfunction

	// elapsed times, all mod 2^32
	logic [TIME_W-1:0] e_fade, e_sleep, e_motion, e_resume;
	logic fading, up, fade_done, motion, scale_direct;
	logic [7:0] direct_val;

	assign e_fade   = now_q - fade_start_q;
	assign e_sleep  = now_q - sleep_start_q;
	assign e_motion = now_q - last_motion_q;
	assign e_resume = now_q - resume_q;

	assign up        = (mode_q == MODE_FADE_IN) || (mode_q == MODE_DREAM_IN);
	assign fading    = up || (mode_q == MODE_FADE_OUT) || (mode_q == MODE_DREAM_OUT);
	assign fade_done = e_fade >= {16'b0, fade_q};
	assign motion    = sum_q >= {2'b0, product_q};

	assign scale_direct = !fading || fade_ge_q;
	assign direct_val   = (up || (mode_q == MODE_AWAKE) || (mode_q == MODE_DREAM_LIT)) ?
		SCALE_FULL : 8'd0;

	// shared restoring divider, one quotient bit a step
	logic [16:0] span, div_d;
	logic [17:0] div_t, div_diff;
	logic        div_ge;

	assign span     = {jitter_q, 1'b1};
	assign div_d    = div_scale_q ? {1'b0, fade_q} : span;
	assign div_t    = {div_r_q, div_sh_q[TIME_W-1]};
	assign div_ge   = div_t >= {1'b0, div_d};
	assign div_diff = div_t - {1'b0, div_d};

	// shared squarer
	logic signed [16:0] sq_op;
	logic signed [33:0] sq_full;

	always_comb begin
		case (cmd.sq_idx)
			SQ_X:    sq_op = $signed({ax_q[15], ax_q}) - $signed({px_q[15], px_q});
			SQ_Y:    sq_op = $signed({ay_q[15], ay_q}) - $signed({py_q[15], py_q});
			SQ_Z:    sq_op = $signed({az_q[15], az_q}) - $signed({pz_q[15], pz_q});
			default: sq_op = $signed({1'b0, thr_q});
		endcase
	end

	assign sq_full = sq_op * sq_op;

	// fade numerator times 255
	logic [23:0] num_255;
	assign num_255 = {num_x_q, 8'b0} - {8'b0, num_x_q};

	assign stat.kind           = kind_q;
	assign stat.sample_use     = ok_q && (mode_q != MODE_ASLEEP);
	assign stat.baseline_valid = bv_q;
	assign stat.scale_direct   = scale_direct;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_timeout_q <= RST_SLEEP_TIMEOUT;
			jitter_q        <= RST_JITTER;
			fade_q          <= RST_FADE;
			dream_int_q     <= RST_DREAM_INTERVAL;
			dream_lit_q     <= RST_DREAM_LIT;
			thr_q           <= RST_MOTION_THR;
			settle_q        <= RST_SETTLE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SLEEP_TIMEOUT:  sleep_timeout_q <= cfg_data;
				CFG_JITTER:         jitter_q        <= cfg_data[15:0];
				CFG_FADE:           fade_q          <= cfg_data[15:0];
				CFG_DREAM_INTERVAL: dream_int_q     <= cfg_data;
				CFG_DREAM_LIT:      dream_lit_q     <= cfg_data[15:0];
				CFG_MOTION_THR:     thr_q           <= cfg_data[15:0];
				CFG_SETTLE:         settle_q        <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_AWAKE;
			fade_start_q  <= '0;
			last_motion_q <= '0;
			sleep_start_q <= '0;
			resume_q      <= '0;
			dream_wait_q  <= RST_DREAM_WAIT;
			timeout_q     <= RST_TIMEOUT;
			bv_q          <= 1'b0;
			seen_q        <= 1'b0;
			fwd_q         <= 1'b0;
			px_q          <= '0;
			py_q          <= '0;
			pz_q          <= '0;
		end else if (cmd.load_in) begin
			seen_q <= 1'b0;
			fwd_q  <= 1'b0;
		end else if (cmd.tick1) begin
			if (mode_q == MODE_ASLEEP) begin
				if (e_sleep >= {7'b0, dream_wait_q}) begin
					mode_q       <= MODE_DREAM_IN;
					fade_start_q <= now_q;
				end
			end else if (fading && fade_done) begin
				if (mode_q == MODE_FADE_OUT || mode_q == MODE_DREAM_OUT) begin
					mode_q        <= MODE_ASLEEP;
					sleep_start_q <= now_q;
					dream_wait_q  <= draw_dream_q;
				end else if (mode_q == MODE_FADE_IN) begin
					mode_q <= MODE_AWAKE;
				end else begin
					mode_q       <= MODE_DREAM_LIT;
					fade_start_q <= now_q;
				end
			end
		end else if (cmd.tick2) begin
			if (mode_q == MODE_DREAM_LIT && e_fade >= {16'b0, dream_lit_q}) begin
				mode_q       <= MODE_DREAM_OUT;
				fade_start_q <= now_q;
			end
		end else if (cmd.tick3) begin
			if (mode_q == MODE_AWAKE && e_motion >= {7'b0, timeout_q}) begin
				mode_q       <= MODE_FADE_OUT;
				fade_start_q <= now_q;
				bv_q         <= 1'b0;
				timeout_q    <= draw_to_q;
			end
		end else if (cmd.base_only) begin
			px_q <= ax_q;
			py_q <= ay_q;
			pz_q <= az_q;
			if (e_resume >= {16'b0, settle_q})
				bv_q <= 1'b1;
		end else if (cmd.decide) begin
			px_q  <= ax_q;
			py_q  <= ay_q;
			pz_q  <= az_q;
			fwd_q <= (mode_q == MODE_AWAKE) || (mode_q == MODE_FADE_IN) ||
				((mode_q == MODE_FADE_OUT) && motion);
			if (motion) begin
				seen_q        <= 1'b1;
				last_motion_q <= now_q;
				if (mode_q == MODE_FADE_OUT) begin
					// reverse the fade at the current brightness
					mode_q       <= MODE_FADE_IN;
					fade_start_q <= now_q - {16'b0, rem_q};
				end
			end
		end else if (cmd.wake) begin
			if (mode_q == MODE_ASLEEP) begin
				last_motion_q <= now_q;
				fade_start_q  <= now_q;
				resume_q      <= now_q;
				bv_q          <= 1'b0;
				mode_q        <= MODE_FADE_IN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= kind;
			now_q  <= now_ms;
			ax_q   <= accel_x;
			ay_q   <= accel_y;
			az_q   <= accel_z;
			ok_q   <= sample_ok;
			rnd_q  <= random_word;
		end
		if (cmd.mod_init) begin
			div_r_q     <= '0;
			div_sh_q    <= rnd_q;
			div_scale_q <= 1'b0;
		end else if (cmd.sc2) begin
			div_r_q     <= {1'b0, num_255[23:8]};
			div_sh_q    <= {num_255[7:0], 24'b0};
			div_scale_q <= 1'b1;
		end else if (cmd.div_step) begin
			div_r_q   <= div_ge ? div_diff[16:0] : div_t[16:0];
			div_sh_q  <= {div_sh_q[TIME_W-2:0], 1'b0};
			div_quo_q <= {div_quo_q[6:0], div_ge};
		end
		if (cmd.draw_calc) begin
			draw_dream_q <= draw_val(dream_int_q, div_r_q, jitter_q);
			draw_to_q    <= draw_val(sleep_timeout_q, div_r_q, jitter_q);
		end
		if (cmd.sq_step) begin
			product_q <= sq_full[31:0];
			if (cmd.sq_idx == SQ_X) begin
				sum_q <= '0;
				rem_q <= fade_done ? 16'd0 : fade_q - e_fade[15:0];
			end else begin
				sum_q <= sum_q + {2'b0, product_q};
			end
		end
		if (cmd.sc1) begin
			fade_ge_q <= fade_done;
			num_x_q   <= up ? e_fade[15:0] : fade_q - e_fade[15:0];
		end
		if (cmd.out_load) begin
			out_mode_q  <= mode_q;
			out_scale_q <= scale_direct ? direct_val : div_quo_q;
			out_radio_q <= (mode_q == MODE_AWAKE) || (mode_q == MODE_FADE_OUT) ||
				(mode_q == MODE_FADE_IN);
			out_seen_q  <= seen_q;
			out_fwd_q   <= fwd_q;
		end
	end

	assign mode             = out_mode_q;
	assign brightness_scale = out_scale_q;
	assign radio_on         = out_radio_q;
	assign motion_seen      = out_seen_q;
	assign forward_sample   = out_fwd_q;

endmodule

[rtl/motion_sleep_fade_controller_unit.sv]
// Channel   Handshake              Payload
// input     in_valid / in_ready    kind, now_ms, accel_x/y/z, sample_ok, random_word
// result    out_valid / out_ready  mode, brightness_scale, radio_on, motion_seen,
//                                  forward_sample
// config    cfg_valid / cfg_ready  cfg_index (0..6), cfg_data (24 bit, masked per reg)
//
// One item at a time; each item gives exactly one result.
// Frame tick: the result waits on the 32-step bit-serial remainder of the random draw
// and, while a fade is still running, the 8-step fade quotient.
// A sample with a baseline makes 4 squarer passes.
// arst_n clears mode to awake and loads register defaults.
// A result held in the output register stalls only the last step of the next item.
module motion_sleep_fade_controller_unit import msfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// item in
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            kind,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic signed [15:0]    accel_x,
	input  logic signed [15:0]    accel_y,
	input  logic signed [15:0]    accel_z,
	input  logic                  sample_ok,
	input  logic [TIME_W-1:0]     random_word,
	// result out
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            mode,
	output logic [7:0]            brightness_scale,
	output logic                  radio_on,
	output logic                  motion_seen,
	output logic                  forward_sample,
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	msfc_cmd_t  cmd;
	msfc_stat_t stat;

	// registers take a write in any cycle; writes are to land between items, which the block does not enforce
	assign cfg_ready = 1'b1;

	// sequencer: dispatches on item kind, steps divider and squarer
	msfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// timing state, mode register, shared divider and squarer, result register
	msfc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.kind             (kind),
		.now_ms           (now_ms),
		.accel_x          (accel_x),
		.accel_y          (accel_y),
		.accel_z          (accel_z),
		.sample_ok        (sample_ok),
		.random_word      (random_word),
		.cfg_we           (cfg_valid & cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mode             (mode),
		.brightness_scale (brightness_scale),
		.radio_on         (radio_on),
		.motion_seen      (motion_seen),
		.forward_sample   (forward_sample)
	);

endmodule

[dv/motion_sleep_fade_controller_unit_test.sv]
`timescale 1ns / 1ps

module motion_sleep_fade_controller_unit_test;
	import msfc_pkg::*;

	// kind code with no meaning: the block must report the mode and change nothing
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int HOLDOFF_CYCLES = 400;
	// longest legal quiet spell is the output hold-off plus one slow tick
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 64;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] now_ms;
		logic [15:0] accel_x;
		logic [15:0] accel_y;
		logic [15:0] accel_z;
		logic        sample_ok;
		logic [31:0] random_word;
	} lamp_event_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] scale;
		logic       radio;
		logic       motion;
		logic       fwd;
	} lamp_status_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] kind;
	logic [31:0] now_ms;
	logic [15:0] accel_x;
	logic [15:0] accel_y;
	logic [15:0] accel_z;
	logic sample_ok;
	logic [31:0] random_word;
	logic out_valid;
	logic out_ready;
	logic [2:0] mode;
	logic [7:0] brightness_scale;
	logic radio_on;
	logic motion_seen;
	logic forward_sample;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	always #2 clk = ~clk;

	motion_sleep_fade_controller_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.kind             (kind),
		.now_ms           (now_ms),
		.accel_x          (accel_x),
		.accel_y          (accel_y),
		.accel_z          (accel_z),
		.sample_ok        (sample_ok),
		.random_word      (random_word),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.mode             (mode),
		.brightness_scale (brightness_scale),
		.radio_on         (radio_on),
		.motion_seen      (motion_seen),
		.forward_sample   (forward_sample),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	// ------------------------------------------------------------------
	// Register shadows, loaded with the reset defaults
	// ------------------------------------------------------------------
	logic [23:0] reg_sleep_timeout = RST_SLEEP_TIMEOUT;
	logic [15:0] reg_jitter        = RST_JITTER;
	logic [15:0] reg_fade          = RST_FADE;
	logic [23:0] reg_dream_gap     = RST_DREAM_INTERVAL;
	logic [15:0] reg_dream_lit     = RST_DREAM_LIT;
	logic [15:0] reg_motion_thr    = RST_MOTION_THR;
	logic [15:0] reg_settle        = RST_SETTLE;

	// ------------------------------------------------------------------
	// Controller state as the testbench sees it
	// ------------------------------------------------------------------
	logic [2:0]  st_mode        = MODE_AWAKE;
	logic [31:0] st_fade_start  = '0;
	logic [31:0] st_last_motion = '0;
	logic [31:0] st_sleep_start = '0;
	logic [31:0] st_dream_wait  = 32'(RST_DREAM_WAIT);
	logic [31:0] st_timeout     = 32'(RST_TIMEOUT);
	logic        st_baseline_ok = 1'b0;
	logic [31:0] st_resume      = '0;
	logic [15:0] st_prev [3]    = '{16'd0, 16'd0, 16'd0};

	lamp_status_t expected_status [$];
	lamp_status_t want_status;

	// stimulus side
	logic [31:0] clock_ms = '0;
	logic [15:0] accel_rest [3] = '{16'd0, 16'd0, 16'd0};
	logic idle_enable = 1'b1;
	int holdoff_requests = 0;
	int holdoff_served = 0;
	int holdoff_left = 0;

	int events_sent = 0;
	int results_checked = 0;
	int reg_writes = 0;
	int settings_applied = 0;
	int mismatches = 0;
	int mode_hits [8] = '{default: 0};

	// base +/- jitter, clamped at zero
	function automatic logic [31:0] jittered(input logic [23:0] base, input logic [31:0] rnd);
		logic [63:0] span;
		logic [63:0] v;
		span = 64'(reg_jitter) * 2 + 1;
		v = 64'(base) + 64'(rnd) % span;
		return (v < 64'(reg_jitter)) ? 32'd0 : 32'(v - 64'(reg_jitter));
	endfunction

	// LED scale for the current mode; fades are linear over reg_fade
	function automatic logic [7:0] scale_at(input logic [31:0] now);
		logic [31:0] e;
		logic up;
		e = now - st_fade_start;
		up = (st_mode == MODE_FADE_IN) || (st_mode == MODE_DREAM_IN);
		if (st_mode == MODE_AWAKE || st_mode == MODE_DREAM_LIT)
			return SCALE_FULL;
		if (st_mode == MODE_ASLEEP)
			return 8'd0;
		if (e >= 32'(reg_fade))
			return up ? SCALE_FULL : 8'd0;
		if (up)
			return 8'(64'(e) * 255 / reg_fade);
		return 8'(64'(32'(reg_fade) - e) * 255 / reg_fade);
	endfunction

	// Frame tick: fades and dream cycle first, then dream-lit expiry, then idle timeout.
	// The order matters: one tick may pass through several of these steps.
	function automatic void advance_frame(input logic [31:0] now, input logic [31:0] rnd);
		if (st_mode == MODE_ASLEEP) begin
			if (now - st_sleep_start >= st_dream_wait) begin
				st_mode = MODE_DREAM_IN;
				st_fade_start = now;
			end
		end else if (st_mode inside {MODE_FADE_OUT, MODE_FADE_IN, MODE_DREAM_IN,
				MODE_DREAM_OUT}) begin
			// a zero fade length means any fade is already over
			if (now - st_fade_start >= 32'(reg_fade)) begin
				if (st_mode == MODE_FADE_OUT || st_mode == MODE_DREAM_OUT) begin
					st_mode = MODE_ASLEEP;
					st_sleep_start = now;
					st_dream_wait = jittered(reg_dream_gap, rnd);
				end else if (st_mode == MODE_FADE_IN) begin
					st_mode = MODE_AWAKE;
				end else begin
					st_mode = MODE_DREAM_LIT;
					st_fade_start = now;
				end
			end
		end
		if (st_mode == MODE_DREAM_LIT && now - st_fade_start >= 32'(reg_dream_lit)) begin
			st_mode = MODE_DREAM_OUT;
			st_fade_start = now;
		end
		if (st_mode == MODE_AWAKE && now - st_last_motion >= st_timeout) begin
			st_mode = MODE_FADE_OUT;
			st_fade_start = now;
			st_baseline_ok = 1'b0;
			st_timeout = jittered(reg_sleep_timeout, rnd);
		end
	endfunction

	// Applies one item to the state copy and returns the status it must produce
	function automatic lamp_status_t next_lamp_status(input lamp_event_t it);
		lamp_status_t res;
		logic [15:0] acc [3];
		logic [63:0] dist2;
		logic [31:0] e;
		longint d;
		res = '0;
		acc = '{it.accel_x, it.accel_y, it.accel_z};
		case (it.kind)
			KIND_TICK: advance_frame(it.now_ms, it.random_word);
			KIND_SAMPLE: begin
				if (it.sample_ok && st_mode != MODE_ASLEEP) begin
					if (!st_baseline_ok) begin
						// still settling: only take the sample as baseline
						st_prev = acc;
						if (it.now_ms - st_resume >= 32'(reg_settle))
							st_baseline_ok = 1'b1;
					end else begin
						dist2 = '0;
						for (int i = 0; i < 3; i++) begin
							d = longint'($signed(acc[i])) - longint'($signed(st_prev[i]));
							dist2 = dist2 + 64'(d * d);
						end
						st_prev = acc;
						if (dist2 >= 64'(reg_motion_thr) * 64'(reg_motion_thr)) begin
							res.motion = 1'b1;
							st_last_motion = it.now_ms;
							if (st_mode == MODE_FADE_OUT) begin
								// turn the fade around at the present level
								e = it.now_ms - st_fade_start;
								st_mode = MODE_FADE_IN;
								st_fade_start = (e >= 32'(reg_fade)) ? it.now_ms :
									it.now_ms - (32'(reg_fade) - e);
							end
						end
						res.fwd = (st_mode == MODE_AWAKE) || (st_mode == MODE_FADE_IN);
					end
				end
			end
			KIND_WAKE: begin
				if (st_mode == MODE_ASLEEP) begin
					st_last_motion = it.now_ms;
					st_fade_start = it.now_ms;
					st_resume = it.now_ms;
					st_baseline_ok = 1'b0;
					st_mode = MODE_FADE_IN;
				end
			end
			default: ;
		endcase
		res.mode = st_mode;
		res.scale = scale_at(it.now_ms);
		res.radio = st_mode inside {MODE_AWAKE, MODE_FADE_OUT, MODE_FADE_IN};
		return res;
	endfunction

	function automatic lamp_event_t make_event(input logic [1:0] k, input logic [31:0] t,
			input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
			input logic ok, input logic [31:0] rnd);
		lamp_event_t it;
		it = '{k, t, x, y, z, ok, rnd};
		return it;
	endfunction

	// Random item: mostly small time steps so fades and timeouts are walked through,
	// now and then a far jump that also carries the clock across the wrap.
	// Samples sit near a drifting rest vector, sometimes shaken, sometimes wild.
	function automatic lamp_event_t next_event(input int unsigned step_max);
		lamp_event_t it;
		int unsigned pick;
		int unsigned spread;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			clock_ms = clock_ms + $urandom;
		else
			clock_ms = clock_ms + $urandom_range(0, step_max);
		pick = $urandom_range(0, 99);
		spread = (pick < 45) ? 2000 : 150;
		for (int i = 0; i < 3; i++) begin
			if (pick < 20)
				accel_rest[i] = 16'($urandom);
			else
				accel_rest[i] = accel_rest[i] + 16'($urandom_range(0, 2 * spread) - spread);
		end
		pick = $urandom_range(0, 99);
		it.kind = (pick < 55) ? KIND_TICK : (pick < 88) ? KIND_SAMPLE :
			(pick < 96) ? KIND_WAKE : KIND_UNUSED;
		it.now_ms = clock_ms;
		it.accel_x = accel_rest[0];
		it.accel_y = accel_rest[1];
		it.accel_z = accel_rest[2];
		it.sample_ok = ($urandom_range(0, 9) != 0);
		it.random_word = $urandom;
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Input side: valid stays up across back-to-back items, dropped only in gaps
	// ------------------------------------------------------------------
	task automatic offer_event(input lamp_event_t it);
		while (idle_enable && $urandom_range(0, 99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= it.kind;
		now_ms      <= it.now_ms;
		accel_x     <= it.accel_x;
		accel_y     <= it.accel_y;
		accel_z     <= it.accel_z;
		sample_ok   <= it.sample_ok;
		random_word <= it.random_word;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_status.push_back(next_lamp_status(it));
		events_sent++;
	endtask

	task automatic run_events(input int count, input int unsigned step_max);
		repeat (count) offer_event(next_event(step_max));
	endtask

	// stop offering and wait until every result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_status.size() != 0);
	endtask

	// Writes all seven registers; upper cfg_data bits of 16-bit registers must be dropped
	task automatic apply_settings(input logic [23:0] t_out, input logic [23:0] jit,
			input logic [23:0] fade, input logic [23:0] dream, input logic [23:0] lit,
			input logic [23:0] thr, input logic [23:0] settle);
		logic [CFG_IDX_W-1:0] order [7];
		logic [23:0] vals [7];
		order = '{CFG_SLEEP_TIMEOUT, CFG_JITTER, CFG_FADE, CFG_DREAM_INTERVAL,
			CFG_DREAM_LIT, CFG_MOTION_THR, CFG_SETTLE};
		vals = '{t_out, jit, fade, dream, lit, thr, settle};
		for (int i = 0; i < 7; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			case (order[i])
				CFG_SLEEP_TIMEOUT:  reg_sleep_timeout = vals[i];
				CFG_JITTER:         reg_jitter = vals[i][15:0];
				CFG_FADE:           reg_fade = vals[i][15:0];
				CFG_DREAM_INTERVAL: reg_dream_gap = vals[i];
				CFG_DREAM_LIT:      reg_dream_lit = vals[i][15:0];
				CFG_MOTION_THR:     reg_motion_thr = vals[i][15:0];
				CFG_SETTLE:         reg_settle = vals[i][15:0];
				default: ;
			endcase
			reg_writes++;
		end
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-built walk through every mode under the reset defaults
	task automatic test_directed_walk();
		offer_event(make_event(KIND_UNUSED, 32'd0, 16'h0, 16'h0, 16'h0, 1'b1, 32'd0));
		// failed read at the top of the clock range, ignored
		offer_event(make_event(KIND_SAMPLE, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			1'b0, 32'd0));
		// first samples: baseline only, then settled once settle time has passed
		offer_event(make_event(KIND_SAMPLE, 32'd100, 16'h7FFF, 16'h8000, 16'h0000,
			1'b1, 32'd0));
		offer_event(make_event(KIND_SAMPLE, 32'd600, 16'h8000, 16'h7FFF, 16'h7FFF,
			1'b1, 32'd0));
		// full-scale swing on every axis, then a quiet one
		offer_event(make_event(KIND_SAMPLE, 32'd700, 16'h7FFF, 16'h8000, 16'h8000,
			1'b1, 32'd0));
		offer_event(make_event(KIND_SAMPLE, 32'd800, 16'h7F9B, 16'h8000, 16'h8000,
			1'b1, 32'd0));
		// wake while awake does nothing
		offer_event(make_event(KIND_WAKE, 32'd900, 16'h0, 16'h0, 16'h0, 1'b1, 32'd0));
		offer_event(make_event(KIND_TICK, 32'd900, 16'h0, 16'h0, 16'h0, 1'b1, 32'd0));
		// idle timeout -> fade out
		offer_event(make_event(KIND_TICK, 32'd240700, 16'h0, 16'h0, 16'h0, 1'b1,
			32'hFFFF_FFFF));
		offer_event(make_event(KIND_SAMPLE, 32'd241300, 16'h0, 16'h0, 16'h0, 1'b1, 32'd0));
		// motion mid fade-out reverses from the present level
		offer_event(make_event(KIND_SAMPLE, 32'd241400, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			1'b1, 32'd0));
		offer_event(make_event(KIND_TICK, 32'd242100, 16'h0, 16'h0, 16'h0, 1'b1, 32'd0));
		offer_event(make_event(KIND_TICK, 32'd541400, 16'h0, 16'h0, 16'h0, 1'b1, 32'd0));
		offer_event(make_event(KIND_SAMPLE, 32'd541500, 16'h0, 16'h0, 16'h0, 1'b1, 32'd0));
		// motion after the fade-out has run its time but before the tick: restart from dark
		offer_event(make_event(KIND_SAMPLE, 32'd542600, 16'h8000, 16'h8000, 16'h8000,
			1'b1, 32'd0));
		offer_event(make_event(KIND_TICK, 32'd543600, 16'h0, 16'h0, 16'h0, 1'b1, 32'd0));
		// fade out all the way into sleep
		offer_event(make_event(KIND_TICK, 32'd842600, 16'h0, 16'h0, 16'h0, 1'b1, 32'd0));
		offer_event(make_event(KIND_TICK, 32'd843600, 16'h0, 16'h0, 16'h0, 1'b1, 32'd0));
		offer_event(make_event(KIND_SAMPLE, 32'd843700, 16'h7FFF, 16'h8000, 16'h7FFF,
			1'b1, 32'd0));
		// dream: in, lit, out, back to sleep
		offer_event(make_event(KIND_TICK, 32'd883600, 16'h0, 16'h0, 16'h0, 1'b1, 32'd0));
		offer_event(make_event(KIND_TICK, 32'd884600, 16'h0, 16'h0, 16'h0, 1'b1, 32'd0));
		offer_event(make_event(KIND_TICK, 32'd886600, 16'h0, 16'h0, 16'h0, 1'b1, 32'd0));
		offer_event(make_event(KIND_TICK, 32'd887600, 16'h0, 16'h0, 16'h0, 1'b1,
			32'hFFFF_FFFF));
		// motion wake, unsettled sample, fade in completes
		offer_event(make_event(KIND_WAKE, 32'd887700, 16'h0, 16'h0, 16'h0, 1'b1, 32'd0));
		offer_event(make_event(KIND_SAMPLE, 32'd887800, 16'h1234, 16'h0, 16'h0, 1'b1, 32'd0));
		offer_event(make_event(KIND_TICK, 32'd888700, 16'h0, 16'h0, 16'h0, 1'b1, 32'd0));
		clock_ms = 32'd888700;
		drain_results();
	endtask

	// short timings so the whole cycle turns over many times
	task automatic test_quick_cycles();
		apply_settings(24'd300, 24'd40, 24'd80, 24'd400, 24'd60, 24'd300, 24'd30);
		run_events(300, 40);
		drain_results();
	endtask

	// all zero (zero fade, zero threshold) with no idling, then all ones
	task automatic test_register_extremes();
		apply_settings(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
		idle_enable <= 1'b0;
		run_events(80, 8);
		drain_results();
		idle_enable <= 1'b1;
		apply_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			24'hFFFFFF, 24'hFFFFFF);
		run_events(100, 20000);
		drain_results();
	endtask

	// jitter far above the base: draws clamp at zero
	task automatic test_draw_saturation();
		apply_settings(24'd10, 24'd65535, 24'd1, 24'd20, 24'd5, 24'd50, 24'd5);
		run_events(100, 30);
		drain_results();
	endtask

	task automatic test_random_settings();
		repeat (3) begin
			apply_settings(24'($urandom_range(0, 600)),
				{8'($urandom), 16'($urandom_range(0, 300))},
				{8'($urandom), 16'($urandom_range(0, 200))},
				24'($urandom_range(0, 800)),
				{8'($urandom), 16'($urandom_range(0, 200))},
				{8'($urandom), 16'($urandom_range(0, 3000))},
				{8'($urandom), 16'($urandom_range(0, 200))});
			run_events(100, 60);
			drain_results();
		end
	endtask

	// receiver holds off while items keep coming: the block backs up and stalls input
	task automatic test_output_holdoff();
		holdoff_requests <= holdoff_requests + 1;
		run_events(80, 40);
		drain_results();
	endtask

	// bursts with the sender waiting for a full drain in between
	task automatic test_sender_pause();
		repeat (3) begin
			run_events(20, 40);
			drain_results();
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: ready drops at random, or for a long hold-off on request
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (holdoff_served != holdoff_requests) begin
			holdoff_served <= holdoff_requests;
			holdoff_left <= HOLDOFF_CYCLES;
			out_ready <= 1'b0;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(idle_enable && $urandom_range(0, 99) < 7);
		end
	end

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// every accepted result is matched against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_status.size() == 0) begin
				$display("%0t: result with nothing expected, mode %0d scale %0d", $time,
					mode, brightness_scale);
				mismatches++;
			end else begin
				want_status = expected_status.pop_front();
				compare_field("mode", 32'(want_status.mode), 32'(mode));
				compare_field("brightness_scale", 32'(want_status.scale),
					32'(brightness_scale));
				compare_field("radio_on", 32'(want_status.radio), 32'(radio_on));
				compare_field("motion_seen", 32'(want_status.motion), 32'(motion_seen));
				compare_field("forward_sample", 32'(want_status.fwd), 32'(forward_sample));
			end
			results_checked++;
			mode_hits[mode]++;
		end
	end

	// ends the run if no channel moves for too long
	initial begin : stall_watch
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
			STALL_LIMIT, expected_status.size());
		$display("** motion_sleep_fade_controller_unit: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_TICK;
		now_ms = '0;
		accel_x = '0;
		accel_y = '0;
		accel_z = '0;
		sample_ok = 1'b0;
		random_word = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SLEEP_TIMEOUT;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_walk();
		test_quick_cycles();
		test_register_extremes();
		test_draw_saturation();
		test_random_settings();
		test_output_holdoff();
		test_sender_pause();

		drain_results();
		// anything still coming out now is unexpected
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items, %0d results checked, %0d register writes over %0d settings",
			events_sent, results_checked, reg_writes, settings_applied);
		$display("results by mode: awake %0d, fade-out %0d, asleep %0d, fade-in %0d, %s%0d %0d %0d",
			mode_hits[MODE_AWAKE], mode_hits[MODE_FADE_OUT], mode_hits[MODE_ASLEEP],
			mode_hits[MODE_FADE_IN], "dream in/lit/out ", mode_hits[MODE_DREAM_IN],
			mode_hits[MODE_DREAM_LIT], mode_hits[MODE_DREAM_OUT]);
		if (mismatches == 0)
			$display("** motion_sleep_fade_controller_unit: PASSED **");
		else
			$display("** motion_sleep_fade_controller_unit: FAILED **");
		$finish;
	end

endmodule
